// ===== src/lced_pkg.sv =====
// lced_pkg: shared types, constants and helpers of the line corner event detector
// used by every module under src; depends on nothing
package lced_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACUTE_NEED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_NEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REARM_NEED = 3'd4;

  localparam logic [7:0] CENTER_BITS = 8'h18;
  localparam logic [7:0] CENTER_ZONE = 8'h3C;
  localparam logic [7:0] NEG_HALF    = 8'h0F;
  localparam logic [7:0] POS_HALF    = 8'hF0;
  localparam logic [7:0] NEG_OUTER   = 8'h07;
  localparam logic [7:0] POS_OUTER   = 8'hE0;
  localparam logic [3:0] FOLLOW_MIN  = 4'd2;

  typedef enum logic [1:0] {
    SHAPE_NONE  = 2'd0,
    SHAPE_RIGHT = 2'd1,
    SHAPE_ACUTE = 2'd2,
    SHAPE_AMBIG = 2'd3
  } shape_e;

  typedef enum logic [1:0] {
    SIDE_UNKNOWN = 2'd0,
    SIDE_NEG     = 2'd1,
    SIDE_POS     = 2'd2
  } side_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
    logic [SAMPLE_W-1:0] sample_4;
    logic [SAMPLE_W-1:0] sample_5;
    logic [SAMPLE_W-1:0] sample_6;
    logic [SAMPLE_W-1:0] sample_7;
    logic [SAMPLE_W-1:0] full_scale;
    logic                line_present;
  } lced_in_t;

  typedef struct packed {
    logic [7:0]  black_bits;
    logic [2:0]  run_total;
    shape_e      seen_shape;
    side_e       seen_side;
    logic        latched;
    logic        new_event;
    shape_e      event_shape;
    side_e       event_side;
    logic [15:0] events_seen;
    logic [15:0] frames_seen;
  } lced_out_t;

  typedef struct packed {
    logic [15:0] threshold;
    logic [3:0]  side_min;
    logic [7:0]  acute_need;
    logic [7:0]  right_need;
    logic [7:0]  rearm_need;
  } lced_cfg_t;

  typedef struct packed {
    logic       frame_skip;
    logic       line_present;
    logic [7:0] mask;
    logic [2:0] runs;
    shape_e     shape;
    side_e      side;
    logic       follow_neg;
    logic       follow_pos;
    logic       centered;
  } lced_class_t;

  function automatic logic [3:0] popcount8(input logic [7:0] m);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'd0, m[i]};
    end
    return c;
  endfunction

endpackage

// ===== src/lced_frontend.sv =====
// lced_frontend: clamps the eight samples, builds the black mask and counts runs
// depends on lced_pkg
module lced_frontend #(
  parameter int SAMPLE_BITS = 16
) (
  input  lced_pkg::lced_in_t frame_i,
  input  logic [15:0]        threshold_i,
  output logic               frame_skip_o,
  output logic [7:0]         mask_o,
  output logic [2:0]         runs_o
);

  logic [lced_pkg::SAMPLE_W-1:0] raw [8];
  logic [SAMPLE_BITS-1:0]        full;
  logic [SAMPLE_BITS-1:0]        b;
  logic [SAMPLE_BITS-1:0]        diff;
  logic [7:0]                    starts;
  logic [3:0]                    run_cnt;

  assign raw[0] = frame_i.sample_0;
  assign raw[1] = frame_i.sample_1;
  assign raw[2] = frame_i.sample_2;
  assign raw[3] = frame_i.sample_3;
  assign raw[4] = frame_i.sample_4;
  assign raw[5] = frame_i.sample_5;
  assign raw[6] = frame_i.sample_6;
  assign raw[7] = frame_i.sample_7;

  assign full = frame_i.full_scale[SAMPLE_BITS-1:0];
  assign frame_skip_o = (full == '0);

  always_comb begin
    mask_o = 8'd0;
    for (int i = 0; i < 8; i++) begin
      b = raw[i][SAMPLE_BITS-1:0];
      if (b > full) begin
        b = full;
      end
      diff = full - b;
      mask_o[i] = (16'(diff) >= threshold_i);
    end
  end

  // a run starts at a set bit whose lower neighbor is clear
  assign starts  = mask_o & ~{mask_o[6:0], 1'b0};
  assign run_cnt = lced_pkg::popcount8(starts);
  assign runs_o  = run_cnt[2:0];

endmodule

// ===== src/lced_classify.sv =====
// lced_classify: shape and side of one mask, acute follow-up and centered tests
// depends on lced_pkg
module lced_classify (
  input  logic [7:0]           mask_i,
  input  logic [2:0]           runs_i,
  input  logic [3:0]           side_min_i,
  output lced_pkg::shape_e     shape_o,
  output lced_pkg::side_e      side_o,
  output logic                 follow_neg_o,
  output logic                 follow_pos_o,
  output logic                 centered_o
);

  logic       center;
  logic       no;
  logic       po;
  logic [3:0] nh;
  logic [3:0] ph;
  logic       n_ok;
  logic       p_ok;

  assign center = (mask_i & lced_pkg::CENTER_BITS) != 8'd0;
  assign no = (mask_i & lced_pkg::NEG_OUTER) != 8'd0;
  assign po = (mask_i & lced_pkg::POS_OUTER) != 8'd0;
  assign nh = lced_pkg::popcount8(mask_i & lced_pkg::NEG_HALF);
  assign ph = lced_pkg::popcount8(mask_i & lced_pkg::POS_HALF);
  assign n_ok = nh >= side_min_i;
  assign p_ok = ph >= side_min_i;

  always_comb begin
    shape_o = lced_pkg::SHAPE_NONE;
    side_o  = lced_pkg::SIDE_UNKNOWN;
    if (center) begin
      if (no && po) begin
        shape_o = lced_pkg::SHAPE_AMBIG;
      end else if (runs_i == 3'd1 && n_ok && !p_ok) begin
        shape_o = lced_pkg::SHAPE_RIGHT;
        side_o  = lced_pkg::SIDE_NEG;
      end else if (runs_i == 3'd1 && p_ok && !n_ok) begin
        shape_o = lced_pkg::SHAPE_RIGHT;
        side_o  = lced_pkg::SIDE_POS;
      end else if (runs_i >= 3'd2 && no) begin
        shape_o = lced_pkg::SHAPE_ACUTE;
        side_o  = lced_pkg::SIDE_NEG;
      end else if (runs_i >= 3'd2 && po) begin
        shape_o = lced_pkg::SHAPE_ACUTE;
        side_o  = lced_pkg::SIDE_POS;
      end
    end
  end

  assign follow_neg_o = center &&
    (lced_pkg::popcount8(mask_i & lced_pkg::NEG_OUTER) >= lced_pkg::FOLLOW_MIN);
  assign follow_pos_o = center &&
    (lced_pkg::popcount8(mask_i & lced_pkg::POS_OUTER) >= lced_pkg::FOLLOW_MIN);
  assign centered_o = (runs_i == 3'd1) && center &&
    ((mask_i & ~lced_pkg::CENTER_ZONE) == 8'd0);

endmodule

// ===== src/lced_tracker.sv =====
// lced_tracker: candidate persistence, event latch, rearm and frame counters
// depends on lced_pkg; produces the result word for the frame being retired
module lced_tracker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  lced_pkg::lced_class_t cls_i,
  input  lced_pkg::lced_cfg_t   cfg_i,
  output lced_pkg::lced_out_t   res_o
);

  logic [15:0]       frm_q, frm_d;
  logic [15:0]       evt_q, evt_d;
  logic [7:0]        mask_q, mask_d;
  logic [2:0]        runs_q, runs_d;
  lced_pkg::shape_e  seen_shape_q, seen_shape_d;
  lced_pkg::side_e   seen_side_q, seen_side_d;
  lced_pkg::shape_e  cand_shape_q, cand_shape_d;
  lced_pkg::side_e   cand_side_q, cand_side_d;
  logic [7:0]        cand_cnt_q, cand_cnt_d;
  lced_pkg::shape_e  last_shape_q, last_shape_d;
  lced_pkg::side_e   last_side_q, last_side_d;
  logic [7:0]        rearm_q, rearm_d;
  logic              latch_q, latch_d;
  logic              fresh;
  logic              follow;
  logic [7:0]        rearm_inc;
  logic [7:0]        need;

  assign rearm_inc = (rearm_q == 8'hFF) ? rearm_q : rearm_q + 8'd1;

  always_comb begin
    case (cand_side_q)
      lced_pkg::SIDE_NEG: follow = cls_i.follow_neg;
      lced_pkg::SIDE_POS: follow = cls_i.follow_pos;
      default:            follow = 1'b0;
    endcase
  end

  always_comb begin
    frm_d        = frm_q;
    evt_d        = evt_q;
    mask_d       = mask_q;
    runs_d       = runs_q;
    seen_shape_d = seen_shape_q;
    seen_side_d  = seen_side_q;
    cand_shape_d = cand_shape_q;
    cand_side_d  = cand_side_q;
    cand_cnt_d   = cand_cnt_q;
    last_shape_d = last_shape_q;
    last_side_d  = last_side_q;
    rearm_d      = rearm_q;
    latch_d      = latch_q;
    fresh        = 1'b0;
    need         = cfg_i.right_need;
    if (!cls_i.frame_skip) begin
      frm_d = frm_q + 16'd1;
      if (!cls_i.line_present) begin
        mask_d       = 8'd0;
        runs_d       = 3'd0;
        seen_shape_d = lced_pkg::SHAPE_NONE;
        seen_side_d  = lced_pkg::SIDE_UNKNOWN;
        cand_shape_d = lced_pkg::SHAPE_NONE;
        cand_side_d  = lced_pkg::SIDE_UNKNOWN;
        cand_cnt_d   = 8'd0;
        rearm_d      = 8'd0;
      end else begin
        mask_d       = cls_i.mask;
        runs_d       = cls_i.runs;
        seen_shape_d = cls_i.shape;
        seen_side_d  = cls_i.side;
        if (latch_q) begin
          cand_shape_d = lced_pkg::SHAPE_NONE;
          cand_side_d  = lced_pkg::SIDE_UNKNOWN;
          cand_cnt_d   = 8'd0;
          if (cls_i.centered) begin
            if (rearm_inc >= cfg_i.rearm_need) begin
              latch_d = 1'b0;
              rearm_d = 8'd0;
            end else begin
              rearm_d = rearm_inc;
            end
          end else begin
            rearm_d = 8'd0;
          end
        end else begin
          rearm_d = 8'd0;
          if (cand_shape_q == lced_pkg::SHAPE_ACUTE && follow) begin
            cand_cnt_d = (cand_cnt_q == 8'hFF) ? cand_cnt_q : cand_cnt_q + 8'd1;
          end else if (cls_i.shape != lced_pkg::SHAPE_RIGHT &&
                       cls_i.shape != lced_pkg::SHAPE_ACUTE) begin
            cand_shape_d = lced_pkg::SHAPE_NONE;
            cand_side_d  = lced_pkg::SIDE_UNKNOWN;
            cand_cnt_d   = 8'd0;
          end else if (cls_i.shape != cand_shape_q || cls_i.side != cand_side_q) begin
            cand_shape_d = cls_i.shape;
            cand_side_d  = cls_i.side;
            cand_cnt_d   = 8'd1;
          end else begin
            cand_cnt_d = (cand_cnt_q == 8'hFF) ? cand_cnt_q : cand_cnt_q + 8'd1;
          end
          if (cand_shape_d == lced_pkg::SHAPE_ACUTE) begin
            need = cfg_i.acute_need;
          end
          // a cleared candidate never latches
          if (cand_shape_d != lced_pkg::SHAPE_NONE && cand_cnt_d >= need) begin
            latch_d      = 1'b1;
            last_shape_d = cand_shape_d;
            last_side_d  = cand_side_d;
            evt_d        = evt_q + 16'd1;
            fresh        = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frm_q        <= 16'd0;
      evt_q        <= 16'd0;
      mask_q       <= 8'd0;
      runs_q       <= 3'd0;
      seen_shape_q <= lced_pkg::SHAPE_NONE;
      seen_side_q  <= lced_pkg::SIDE_UNKNOWN;
      cand_shape_q <= lced_pkg::SHAPE_NONE;
      cand_side_q  <= lced_pkg::SIDE_UNKNOWN;
      cand_cnt_q   <= 8'd0;
      last_shape_q <= lced_pkg::SHAPE_NONE;
      last_side_q  <= lced_pkg::SIDE_UNKNOWN;
      rearm_q      <= 8'd0;
      latch_q      <= 1'b0;
    end else if (step_i) begin
      frm_q        <= frm_d;
      evt_q        <= evt_d;
      mask_q       <= mask_d;
      runs_q       <= runs_d;
      seen_shape_q <= seen_shape_d;
      seen_side_q  <= seen_side_d;
      cand_shape_q <= cand_shape_d;
      cand_side_q  <= cand_side_d;
      cand_cnt_q   <= cand_cnt_d;
      last_shape_q <= last_shape_d;
      last_side_q  <= last_side_d;
      rearm_q      <= rearm_d;
      latch_q      <= latch_d;
    end
  end

  assign res_o.black_bits  = mask_d;
  assign res_o.run_total   = runs_d;
  assign res_o.seen_shape  = seen_shape_d;
  assign res_o.seen_side   = seen_side_d;
  assign res_o.latched     = latch_d;
  assign res_o.new_event   = fresh;
  assign res_o.event_shape = last_shape_d;
  assign res_o.event_side  = last_side_d;
  assign res_o.events_seen = evt_d;
  assign res_o.frames_seen = frm_d;

endmodule

// ===== src/line_corner_event_detector.sv =====
// Line corner event detector. Takes one frame word of eight brightness samples per cycle
// while the output takes words and returns one result word for every frame, in order.
// A frame passes an input register, then mask building, classification and the tracker
// update run combinationally as the word moves into the result register, so a new frame
// is accepted on every clock while the output keeps taking words. The tracker state is
// updated once per frame as its word is retired. Configuration registers are written
// through the plain write port while idle, a user rule that the block does not enforce.
module line_corner_event_detector #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  lced_pkg::lced_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lced_pkg::lced_out_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [lced_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lced_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  lced_pkg::lced_cfg_t   cfg_q;
  lced_pkg::lced_in_t    in_data_q;
  logic                  in_valid_q;
  lced_pkg::lced_out_t   out_data_q;
  logic                  out_valid_q;
  logic                  step;
  lced_pkg::lced_class_t cls;
  lced_pkg::lced_out_t   res;

  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold  <= 16'd2048;
      cfg_q.side_min   <= 4'd3;
      cfg_q.acute_need <= 8'd2;
      cfg_q.right_need <= 8'd3;
      cfg_q.rearm_need <= 8'd5;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lced_pkg::CFG_THRESHOLD:  cfg_q.threshold  <= cfg_data_i;
        lced_pkg::CFG_SIDE_MIN:   cfg_q.side_min   <= cfg_data_i[3:0];
        lced_pkg::CFG_ACUTE_NEED: cfg_q.acute_need <= cfg_data_i[7:0];
        lced_pkg::CFG_RIGHT_NEED: cfg_q.right_need <= cfg_data_i[7:0];
        lced_pkg::CFG_REARM_NEED: cfg_q.rearm_need <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
    if (step) begin
      out_data_q <= res;
    end
  end

  lced_frontend #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_frontend (
    .frame_i     (in_data_q),
    .threshold_i (cfg_q.threshold),
    .frame_skip_o(cls.frame_skip),
    .mask_o      (cls.mask),
    .runs_o      (cls.runs)
  );

  assign cls.line_present = in_data_q.line_present;

  lced_classify u_classify (
    .mask_i      (cls.mask),
    .runs_i      (cls.runs),
    .side_min_i  (cfg_q.side_min),
    .shape_o     (cls.shape),
    .side_o      (cls.side),
    .follow_neg_o(cls.follow_neg),
    .follow_pos_o(cls.follow_pos),
    .centered_o  (cls.centered)
  );

  lced_tracker u_tracker (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .cls_i (cls),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_event_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.new_event |-> out_data_q.latched)
    else $error("new event without latch");

  a_event_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.new_event |->
      (out_data_q.event_shape == lced_pkg::SHAPE_RIGHT ||
       out_data_q.event_shape == lced_pkg::SHAPE_ACUTE))
    else $error("confirmed event has no corner shape");

  a_sided_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_data_q.seen_shape == lced_pkg::SHAPE_RIGHT ||
                    out_data_q.seen_shape == lced_pkg::SHAPE_ACUTE) |->
      out_data_q.seen_side != lced_pkg::SIDE_UNKNOWN)
    else $error("corner shape without side");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q.run_total <= 3'd4)
    else $error("run count out of range");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

endmodule
